FILE: rtl/radix_digit_emitter_defines.svh
// ---------------------------------------------------------------------------
// radix_digit_emitter_defines: assertion macros
// Shared concurrent assertion forms used by the checker of the emitter.
// ---------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RDE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rde check failed");

// next-cycle implication, disabled during reset
`define RDE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rde check failed");

// state in the cycle after a reset cycle
`define RDE_ASSERT_RST(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("rde reset check failed");

`endif

FILE: rtl/rde_pkg.sv
// ---------------------------------------------------------------------------
// rde_pkg: shared types and constants
// Widths, register selects, sign characters and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

   localparam int VALUE_W           = 64;
   localparam int CHAR_W            = 8;
   localparam int ALPHA_BYTES       = 16;
   localparam int DEFAULT_MAX_RADIX = 16;
   localparam int DIGITS_MAX        = 64;
   localparam int DIG_IDX_W         = $clog2(DIGITS_MAX);
   localparam int BYTE_STEPS        = VALUE_W / CHAR_W;
   localparam int STEP_CNT_W        = $clog2(BYTE_STEPS);

   localparam int CSR_ADDR_W        = 4;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_SEL_BIT       = 3;

   localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
   localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

   typedef enum logic {
      CSR_ALPHA_LOW  = 1'b0,
      CSR_ALPHA_HIGH = 1'b1
   } csr_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/rde_div_step.sv
// ---------------------------------------------------------------------------
// rde_div_step: one byte of long division by the radix
// Restoring division of {remainder, byte} by a small radix, one bit per
// stage; gives the quotient byte and the new remainder.
// ---------------------------------------------------------------------------
`default_nettype none

module rde_div_step
   import rde_pkg::*;
#(
   parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
   input  wire logic [$clog2(MAX_RADIX+1)-1:0] radix,
   input  wire logic [$clog2(MAX_RADIX)-1:0]   rem_in,
   input  wire logic [CHAR_W-1:0]              byte_in,
   output logic      [CHAR_W-1:0]              quot_out,
   output logic      [$clog2(MAX_RADIX)-1:0]   rem_out
);

   localparam int DIGIT_W = $clog2(MAX_RADIX);
   localparam int T_W     = DIGIT_W + 1;

   always_comb begin
      logic [T_W-1:0]     t;
      logic [DIGIT_W-1:0] r;
      r        = rem_in;
      quot_out = '0;
      for (int i = CHAR_W - 1; i >= 0; i--) begin
         t = {r, byte_in[i]};
         if (t >= T_W'(radix)) begin
            quot_out[i] = 1'b1;
            r           = DIGIT_W'(t - T_W'(radix));
         end else begin
            r = DIGIT_W'(t);
         end
      end
      rem_out = r;
   end

endmodule

`default_nettype wire

FILE: rtl/rde_alpha_check.sv
// ---------------------------------------------------------------------------
// rde_alpha_check: alphabet length and validity
// Finds the alphabet length up to the first zero byte and registers the
// radix, or zero when the alphabet is short, has a sign or repeats a char.
// ---------------------------------------------------------------------------
`default_nettype none

module rde_alpha_check
   import rde_pkg::*;
#(
   parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [CSR_DATA_W-1:0]          alphabet_low,
   input  wire logic [CSR_DATA_W-1:0]          alphabet_high,
   output logic      [$clog2(MAX_RADIX+1)-1:0] radix
);

   localparam int RADIX_W = $clog2(MAX_RADIX + 1);
   localparam int LIMIT   = (MAX_RADIX > ALPHA_BYTES) ? ALPHA_BYTES : MAX_RADIX;

   logic [2*CSR_DATA_W-1:0] alpha_vec;
   logic [RADIX_W-1:0]      radix_ff;
   logic [RADIX_W-1:0]      radix_in;

   assign alpha_vec = {alphabet_high, alphabet_low};

   always_comb begin
      logic [RADIX_W-1:0] len;
      logic               found;
      logic               bad;
      len   = RADIX_W'(LIMIT);
      found = 1'b0;
      bad   = 1'b0;
      for (int i = 0; i < LIMIT; i++) begin
         if (!found && alpha_vec[i*CHAR_W +: CHAR_W] == '0) begin
            len   = RADIX_W'(i);
            found = 1'b1;
         end
      end
      for (int i = 0; i < LIMIT; i++) begin
         if (RADIX_W'(i) < len && (alpha_vec[i*CHAR_W +: CHAR_W] == PLUS_CHAR ||
                                   alpha_vec[i*CHAR_W +: CHAR_W] == MINUS_CHAR)) begin
            bad = 1'b1;
         end
         for (int j = i + 1; j < LIMIT; j++) begin
            if (RADIX_W'(j) < len &&
                alpha_vec[i*CHAR_W +: CHAR_W] == alpha_vec[j*CHAR_W +: CHAR_W]) begin
               bad = 1'b1;
            end
         end
      end
      radix_in = (len < RADIX_W'(2) || bad) ? '0 : len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign radix = radix_ff;

endmodule

`default_nettype wire

FILE: rtl/radix_digit_emitter.sv
// ---------------------------------------------------------------------------
// radix_digit_emitter: 64-bit value to digits of a configured alphabet
// Each digit takes one pass of the byte-wide divide step over the value; all n
// digits (n up to 64) are found first, then read back from the digit RAM.
// Digit beats go out one per cycle while the output is not stalled; the next
// item is taken only after the last digit is read, and the cycle after a
// register write holds input off; with an unusable alphabet a value is dropped.
// Reset clears sequencer, output valid and both alphabet registers.
// ---------------------------------------------------------------------------
`default_nettype none

module radix_digit_emitter
   import rde_pkg::*;
#(
   parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [VALUE_W-1:0]    req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [CHAR_W-1:0]     rsp_digit_char,
   output logic                       rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int DIGIT_W = $clog2(MAX_RADIX);
   localparam int RADIX_W = $clog2(MAX_RADIX + 1);

   // configuration
   logic [CSR_DATA_W-1:0]   alpha_low_ff,  alpha_low_in;
   logic [CSR_DATA_W-1:0]   alpha_high_ff, alpha_high_in;
   logic [2*CSR_DATA_W-1:0] alpha_vec;
   logic                    csr_wr;
   csr_sel_type             csr_sel;
   logic [RADIX_W-1:0]      radix;
   logic [CHAR_W-1:0]       char_tab [MAX_RADIX];
   logic                    cfg_wait_ff, cfg_wait_in;

   // sequencer and divide datapath
   state_type               state_ff, state_in;
   logic [VALUE_W-1:0]      work_ff,  work_in;
   logic [DIGIT_W-1:0]      rem_ff,   rem_in;
   logic [STEP_CNT_W-1:0]   step_ff,  step_in;
   logic [DIG_IDX_W-1:0]    ndig_ff,  ndig_in;
   logic [DIG_IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [CHAR_W-1:0]       div_quot;
   logic [DIGIT_W-1:0]      div_rem;
   logic [VALUE_W-1:0]      quot_next;
   logic                    quot_zero;
   logic                    pass_end;
   logic                    ndig_full;
   logic                    req_accept;
   logic                    mem_we;
   logic                    rd_en;

   // digit store, filled least significant first
   logic [DIGIT_W-1:0]      digit_mem [DIGITS_MAX];

   // read stage and output register
   logic                    a_valid_ff, a_valid_in;
   logic                    a_last_ff;
   logic [DIGIT_W-1:0]      rd_data_ff;
   logic                    a_free;
   logic                    b_load;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff;
   logic                    rsp_last_ff;

   // ------------------------------------------------------------ csr port
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = csr_sel_type'(csr_paddr[CSR_SEL_BIT]);
   assign csr_pready = 1'b1;

   // radix is registered after the alphabet registers; input is held off in the cycle after a write
   assign cfg_wait_in = csr_wr;

   always_comb begin
      alpha_low_in  = alpha_low_ff;
      alpha_high_in = alpha_high_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            CSR_ALPHA_LOW:  alpha_low_in  = csr_pwdata;
            CSR_ALPHA_HIGH: alpha_high_in = csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_ALPHA_LOW:  csr_prdata = alpha_low_ff;
         CSR_ALPHA_HIGH: csr_prdata = alpha_high_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
         cfg_wait_ff   <= 1'b0;
      end else begin
         alpha_low_ff  <= alpha_low_in;
         alpha_high_ff <= alpha_high_in;
         cfg_wait_ff   <= cfg_wait_in;
      end
   end

   assign alpha_vec = {alpha_high_ff, alpha_low_ff};

   always_comb begin
      for (int i = 0; i < MAX_RADIX; i++) begin
         char_tab[i] = alpha_vec[i*CHAR_W +: CHAR_W];
      end
   end

   rde_alpha_check #(
      .MAX_RADIX     (MAX_RADIX)
   ) u_alpha_check (
      .clock         (clock),
      .reset         (reset),
      .alphabet_low  (alpha_low_ff),
      .alphabet_high (alpha_high_ff),
      .radix         (radix)
   );

   // ------------------------------------------------------------ divide unit
   rde_div_step #(
      .MAX_RADIX (MAX_RADIX)
   ) u_div_step (
      .radix     (radix),
      .rem_in    (rem_ff),
      .byte_in   (work_ff[VALUE_W-1 -: CHAR_W]),
      .quot_out  (div_quot),
      .rem_out   (div_rem)
   );

   // value rotates left a byte per cycle; after a pass it holds the quotient
   assign quot_next  = {work_ff[VALUE_W-CHAR_W-1:0], div_quot};
   assign quot_zero  = (quot_next == '0);
   assign pass_end   = (step_ff == STEP_CNT_W'(BYTE_STEPS - 1));
   assign ndig_full  = (ndig_ff == DIG_IDX_W'(DIGITS_MAX - 1));
   assign req_accept = req_valid & ~req_stall;

   assign b_load = a_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign a_free = ~a_valid_ff | b_load;

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && radix != '0) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (pass_end && (quot_zero || ndig_full)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rd_en && rd_idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = cfg_wait_ff;
         ST_DIV:  mem_we    = pass_end;
         ST_EMIT: rd_en     = a_free;
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      work_in   = work_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      ndig_in   = ndig_ff;
      rd_idx_in = rd_idx_ff;
      if (req_accept) begin
         work_in = req_value;
         rem_in  = '0;
         step_in = '0;
         ndig_in = '0;
      end else if (state_ff == ST_DIV) begin
         work_in = quot_next;
         step_in = step_ff + 1'b1;
         rem_in  = pass_end ? '0 : div_rem;
         if (pass_end) begin
            ndig_in   = ndig_ff + 1'b1;
            rd_idx_in = ndig_ff;
         end
      end
      // most significant digit is read first
      if (rd_en) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   assign a_valid_in   = rd_en | (a_valid_ff & ~b_load);
   assign rsp_valid_in = b_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         ndig_ff      <= '0;
         rd_idx_ff    <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ndig_ff      <= ndig_in;
         rd_idx_ff    <= rd_idx_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      if (rd_en) begin
         a_last_ff <= (rd_idx_ff == '0);
      end
      if (b_load) begin
         rsp_char_ff <= char_tab[rd_data_ff];
         rsp_last_ff <= a_last_ff;
      end
   end

   // ------------------------------------------------------------ digit ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[ndig_ff] <= div_rem;
      end
      if (rd_en) begin
         rd_data_ff <= digit_mem[rd_idx_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/rde_checker.sv
// ---------------------------------------------------------------------------
// rde_checker: port-level checks for the digit emitter
// Watches the top-level ports over time; attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "radix_digit_emitter_defines.svh"

module rde_checker
   import rde_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [CHAR_W-1:0]     rsp_digit_char,
   input wire logic                  rsp_last,
   input wire logic                  csr_psel,
   input wire logic                  csr_penable,
   input wire logic                  csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [CSR_DATA_W-1:0] csr_prdata,
   input wire logic                  csr_pready
);

   // stalled beat holds
   `RDE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last))

   // out of reset: nothing pending, input open
   `RDE_ASSERT_RST(a_reset_idle, clock, reset, !rsp_valid && !req_stall)

   // no wait states on the csr port
   `RDE_ASSERT_IMP(a_pready, clock, reset, 1'b1, csr_pready)

   // a written register reads back the beat just written
   `RDE_ASSERT_IMP(a_readback, clock, reset, (csr_psel && csr_penable && csr_pwrite && !reset) ##1 (csr_paddr[CSR_SEL_BIT] == $past(csr_paddr[CSR_SEL_BIT])), csr_prdata == $past(csr_pwdata))

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (.*);

`default_nettype wire

FILE: sim/digit_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// digit_stream_checker: digit predictor and scoreboard for the emitter
// Mirrors the alphabet registers from the CSR port and expands each accepted
// value into its digit beats. Each accepted digit beat is compared with the
// oldest expected one.
// ---------------------------------------------------------------------------

module digit_stream_checker
   import rde_pkg::*;
#(
   parameter int MAX_RADIX = DEFAULT_MAX_RADIX
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [VALUE_W-1:0]    req_value,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [CHAR_W-1:0]     rsp_digit_char,
   input  wire logic                  rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                  csr_pready,
   input  wire logic                  end_check,
   output int                         pending_digits,
   output int                         fail_count
);

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_beat_type;

   digit_beat_type               expected_digits[$];
   logic [2*CSR_DATA_W-1:0]      alphabet = '0;   // {alphabet_high, alphabet_low}
   int                           failures = 0;
   logic                         end_seen = 1'b0;

   initial begin
      pending_digits = 0;
      fail_count     = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t digit check: %s", $time, msg);
      failures++;
   endtask

   // radix of the alphabet, or 0 when it cannot be used
   function automatic int unsigned alphabet_radix(input logic [2*CSR_DATA_W-1:0] alpha);
      int unsigned       cap;
      int unsigned       len;
      logic [CHAR_W-1:0] ci;
      cap = (MAX_RADIX > ALPHA_BYTES) ? ALPHA_BYTES : MAX_RADIX;
      len = 0;
      while (len < cap && alpha[CHAR_W*len +: CHAR_W] != '0) len++;
      if (len < 2) return 0;
      for (int i = 0; i < len; i++) begin
         ci = alpha[CHAR_W*i +: CHAR_W];
         if (ci == PLUS_CHAR || ci == MINUS_CHAR) return 0;
         for (int j = i + 1; j < len; j++) begin
            if (alpha[CHAR_W*j +: CHAR_W] == ci) return 0;
         end
      end
      return len;
   endfunction

   task automatic predict_digits(input logic [VALUE_W-1:0] value);
      logic [3:0]         digit_seq [DIGITS_MAX];
      logic [VALUE_W-1:0] rest;
      int unsigned        radix;
      int unsigned        n;
      digit_beat_type     beat;
      radix = alphabet_radix(alphabet);
      if (radix == 0) return;
      rest = value;
      n    = 0;
      // least significant digit first, emitted in reverse
      do begin
         digit_seq[n] = 4'(rest % radix);
         rest = rest / radix;
         n++;
      end while (rest != 0 && n < DIGITS_MAX);
      for (int k = 0; k < n; k++) begin
         beat.digit_char = alphabet[CHAR_W*int'(digit_seq[n-1-k]) +: CHAR_W];
         beat.last       = (k == n - 1);
         expected_digits.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      digit_beat_type want;
      if (reset) begin
         expected_digits.delete();
         alphabet <= '0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_digits.size() == 0) begin
               report_mismatch($sformatf("digit beat 0x%02h with nothing expected",
                                         rsp_digit_char));
            end else begin
               want = expected_digits.pop_front();
               if (rsp_digit_char !== want.digit_char)
                  report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
                                            rsp_digit_char, want.digit_char));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) predict_digits(req_value);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_sel_type'(csr_paddr[CSR_SEL_BIT]) == CSR_ALPHA_HIGH)
               alphabet[2*CSR_DATA_W-1:CSR_DATA_W] <= csr_pwdata;
            else
               alphabet[CSR_DATA_W-1:0] <= csr_pwdata;
         end
         if (end_check && !end_seen) begin
            end_seen <= 1'b1;
            if (expected_digits.size() != 0)
               report_mismatch($sformatf("%0d digit beats never arrived",
                                         expected_digits.size()));
         end
      end
      pending_digits <= expected_digits.size();
      fail_count     <= failures;
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for radix_digit_emitter
// Programs a series of alphabets (valid, invalid and boundary ones) through
// the CSR port between drained phases, sends directed then random values with
// random gaps and output stalls, and leaves checking to the digit checker.
// ---------------------------------------------------------------------------

module testbench;
   import rde_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 9 * DIGITS_MAX + 64;
   localparam int RANDOM_ITEMS  = 390;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic [VALUE_W-1:0]    req_value      = '0;
   logic                  rsp_stall      = 1'b0;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic                  end_check      = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [CHAR_W-1:0]     rsp_digit_char;
   logic                  rsp_last;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    pending_digits;
   int                    fail_count;
   int                    idle_cycles    = 0;
   bit                    no_idle        = 1'b0;

   radix_digit_emitter #(
      .MAX_RADIX (DEFAULT_MAX_RADIX)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   digit_stream_checker #(
      .MAX_RADIX (DEFAULT_MAX_RADIX)
   ) u_digit_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .end_check      (end_check),
      .pending_digits (pending_digits),
      .fail_count     (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on cycles without any beat or register write
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // output side: random stall before each digit beat
   initial begin
      int unsigned hold;
      while (reset) @(posedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   function automatic logic [2*CSR_DATA_W-1:0] pack_alphabet(input string s);
      logic [2*CSR_DATA_W-1:0] a;
      a = '0;
      for (int i = 0; i < s.len() && i < ALPHA_BYTES; i++) a[CHAR_W*i +: CHAR_W] = s[i];
      return a;
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0:       return VALUE_W'($urandom_range(0, 40));
         1:       return {VALUE_W{1'b1}} >> $urandom_range(0, 8);
         default: return {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
      endcase
   endfunction

   // distinct nonzero characters, garbage past the terminator, sometimes spoiled
   task automatic random_alphabet(output logic [2*CSR_DATA_W-1:0] alpha, output bit usable);
      int unsigned       len;
      int unsigned       pos;
      logic [CHAR_W-1:0] c;
      bit                clash;
      alpha = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       len = $urandom_range(0, 1);
         1:       len = 2;
         2:       len = ALPHA_BYTES;
         default: len = $urandom_range(2, ALPHA_BYTES);
      endcase
      for (int i = 0; i < len; i++) begin
         do begin
            c     = CHAR_W'($urandom_range(1, 255));
            clash = (c == PLUS_CHAR || c == MINUS_CHAR);
            for (int j = 0; j < i; j++) begin
               if (alpha[CHAR_W*j +: CHAR_W] == c) clash = 1'b1;
            end
         end while (clash);
         alpha[CHAR_W*i +: CHAR_W] = c;
      end
      if (len < ALPHA_BYTES) alpha[CHAR_W*len +: CHAR_W] = '0;
      usable = (len >= 2);
      if (usable && $urandom_range(0, 7) == 0) begin
         pos = $urandom_range(0, len - 1);
         case ($urandom_range(0, 2))
            0:       alpha[CHAR_W*pos +: CHAR_W] = PLUS_CHAR;
            1:       alpha[CHAR_W*pos +: CHAR_W] = MINUS_CHAR;
            default: alpha[CHAR_W*pos +: CHAR_W] = alpha[CHAR_W*((pos + 1) % len) +: CHAR_W];
         endcase
         usable = 1'b0;
      end
   endtask

   task automatic send_value(input logic [VALUE_W-1:0] v);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // drain all digits, then let an item with no digits finish its passes
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_digits != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_sel_type sel, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(sel) << CSR_SEL_BIT;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_alphabet(input logic [2*CSR_DATA_W-1:0] alpha);
      wait_quiet();
      write_csr(CSR_ALPHA_LOW, alpha[CSR_DATA_W-1:0]);
      write_csr(CSR_ALPHA_HIGH, alpha[2*CSR_DATA_W-1:CSR_DATA_W]);
      no_idle = ($urandom_range(0, 3) == 0);
   endtask

   initial begin
      logic [2*CSR_DATA_W-1:0] alpha;
      bit                      usable;
      int unsigned             n_items;
      int unsigned             counted;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty alphabet out of reset: nothing comes out
      send_value('0);
      send_value({VALUE_W{1'b1}});

      // binary, including the longest run of digits
      program_alphabet(pack_alphabet("01"));
      send_value('0);
      send_value(VALUE_W'(1));
      send_value({VALUE_W{1'b1}});
      send_value({1'b1, {(VALUE_W-1){1'b0}}});

      // full sixteen characters, no terminator
      program_alphabet(pack_alphabet("0123456789ABCDEF"));
      send_value('0);
      send_value({VALUE_W{1'b1}});
      send_value(64'h0123_4567_89AB_CDEF);

      // radix 7, bytes past the terminator are junk
      alpha = pack_alphabet("0123456");
      alpha[2*CSR_DATA_W-1:CSR_DATA_W] = {CSR_DATA_W{1'b1}};
      program_alphabet(alpha);
      send_value('0);
      send_value(VALUE_W'(6));
      send_value(VALUE_W'(7));
      send_value({VALUE_W{1'b1}});

      // characters with the top bits set
      for (int i = 0; i < ALPHA_BYTES; i++) alpha[CHAR_W*i +: CHAR_W] = CHAR_W'(8'hF0 + i);
      program_alphabet(alpha);
      send_value(64'hFEDC_BA98_7654_3210);
      send_value(VALUE_W'(15));

      // unusable alphabets: too short, sign characters, repeats
      program_alphabet(pack_alphabet("A"));
      send_value(random_value());
      program_alphabet(pack_alphabet("0+"));
      send_value(random_value());
      program_alphabet(pack_alphabet("01-"));
      send_value(random_value());
      program_alphabet(pack_alphabet("0120"));
      send_value(random_value());
      program_alphabet({2*CSR_DATA_W{1'b1}});
      send_value({VALUE_W{1'b1}});

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         random_alphabet(alpha, usable);
         program_alphabet(alpha);
         n_items = usable ? $urandom_range(8, 30) : $urandom_range(1, 3);
         repeat (n_items) send_value(random_value());
         if (usable) counted += n_items;
      end

      wait_quiet();
      end_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
